// ----- design/pvl_pkg.sv -----
package pvl_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int SPECULAR_POWER_DEF = 4;

    // one result bit per isqrt stage, radicand is 62 bits wide
    localparam int ISQRT_STEPS = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [47:0] VIEW_DIR_RESET = 48'h0000_0000_4000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AMBIENT_COLOR    = 3'd0,
        REG_LIGHT_COLOR      = 3'd1,
        REG_LIGHT_DIRECTION  = 3'd2,
        REG_VIEW_DIRECTION   = 3'd3,
        REG_AMBIENT_REFLECT  = 3'd4,
        REG_DIFFUSE_REFLECT  = 3'd5,
        REG_SPECULAR_REFLECT = 3'd6
    } reg_index_t;

    function automatic int norm_latency(input int f);
        return ISQRT_STEPS + f + 2 + 4;
    endfunction

    function automatic int shade_latency(input int p);
        return p + 8;
    endfunction

    // shift right with rounding half away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int sh);
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] res;
        half = 64'd1 << (sh - 1);
        mag  = x[63] ? 64'(-x) : 64'(x);
        res  = (mag + half) >> sh;
        return x[63] ? -$signed(res) : $signed(res);
    endfunction

endpackage

// ----- design/pvl_norm.sv -----
module pvl_norm #(
    parameter int F = pvl_pkg::COMPONENT_BITS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  vec  [3],
    output logic signed [F+1:0] unit [3]
);

    localparam int QW = F + 2;
    localparam int NW = 16 + F + 15 + 1;
    localparam int SQ = pvl_pkg::ISQRT_STEPS;

    logic [15:0] mag_c [3];
    logic        neg_c [3];
    logic [16:0] ext_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ext_c[i] = {vec[i][15], vec[i]};
            neg_c[i] = vec[i][15];
            mag_c[i] = ext_c[i][16] ? 16'(-ext_c[i]) : ext_c[i][15:0];
        end
    end

    logic [31:0] sq_reg   [3];
    logic [15:0] maga_reg [3];
    logic        nega_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= 32'(mag_c[i]) * 32'(mag_c[i]);
                maga_reg[i] <= mag_c[i];
                nega_reg[i] <= neg_c[i];
            end
        end
    end

    logic [63:0] x_reg    [0:SQ];
    logic [63:0] r_reg    [0:SQ];
    logic [15:0] mag_reg  [0:SQ][3];
    logic        neg_reg  [0:SQ][3];
    logic        zero_reg [0:SQ];
    logic [33:0] m2_c;

    assign m2_c = 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= 64'({m2_c[31:0], 30'b0});
            r_reg[0]    <= '0;
            zero_reg[0] <= (m2_c == '0);
            mag_reg[0]  <= maga_reg;
            neg_reg[0]  <= nega_reg;
        end
    end

    for (genvar k = 1; k <= SQ; k++)
    begin : g_isqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
        logic [63:0] trial_c;
        assign trial_c = r_reg[k-1] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (x_reg[k-1] >= trial_c)
                begin
                    x_reg[k] <= x_reg[k-1] - trial_c;
                    r_reg[k] <= (r_reg[k-1] >> 1) + BIT;
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1];
                    r_reg[k] <= r_reg[k-1] >> 1;
                end
                zero_reg[k] <= zero_reg[k-1];
                mag_reg[k]  <= mag_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    logic [31:0]   s_reg     [0:QW];
    logic [31:0]   rem_reg   [0:QW][3];
    logic [QW-1:0] low_reg   [0:QW][3];
    logic [QW-1:0] q_reg     [0:QW][3];
    logic          negd_reg  [0:QW][3];
    logic          zerod_reg [0:QW];
    logic [NW-1:0] num_c     [3];
    logic [31:0]   s_c;

    assign s_c = r_reg[SQ][31:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_c[i] = (NW'(mag_reg[SQ][i]) << (F + 15)) + NW'(s_c >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0]     <= s_c;
            zerod_reg[0] <= zero_reg[SQ];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i]  <= 32'(num_c[i] >> QW);
                low_reg[0][i]  <= num_c[i][QW-1:0];
                q_reg[0][i]    <= '0;
                negd_reg[0][i] <= neg_reg[SQ][i];
            end
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [32:0] trial_c [3];
        logic        ge_c    [3];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial_c[i] = {rem_reg[k-1][i], low_reg[k-1][i][QW-k]};
                ge_c[i]    = trial_c[i] >= {1'b0, s_reg[k-1]};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k]     <= s_reg[k-1];
                zerod_reg[k] <= zerod_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k][i]  <= ge_c[i] ? 32'(trial_c[i] - {1'b0, s_reg[k-1]})
                                              : trial_c[i][31:0];
                    q_reg[k][i]    <= {q_reg[k-1][i][QW-2:0], ge_c[i]};
                    low_reg[k][i]  <= low_reg[k-1][i];
                    negd_reg[k][i] <= negd_reg[k-1][i];
                end
            end
        end
    end

    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic [QW-1:0]       qc_c   [3];
    logic signed [F+1:0] unit_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qc_c[i] = (q_reg[QW][i] > ONE) ? ONE : q_reg[QW][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (zerod_reg[QW])
                begin
                    unit_reg[i] <= '0;
                end
                else if (negd_reg[QW][i])
                begin
                    unit_reg[i] <= -$signed(qc_c[i]);
                end
                else
                begin
                    unit_reg[i] <= $signed(qc_c[i]);
                end
            end
        end
    end

    assign unit = unit_reg;

endmodule

// ----- design/pvl_shade.sv -----
module pvl_shade #(
    parameter int F = pvl_pkg::COMPONENT_BITS_DEF,
    parameter int P = pvl_pkg::SPECULAR_POWER_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [F+1:0] n_unit [3],
    input  logic signed [F+1:0] l_unit [3],
    input  logic signed [F+1:0] v_unit [3],
    input  logic [23:0]         ambient_color,
    input  logic [23:0]         light_color,
    input  logic [47:0]         ambient_reflect,
    input  logic [47:0]         diffuse_reflect,
    input  logic [47:0]         specular_reflect,
    output logic [2:0][7:0]     color
);

    localparam int UW  = F + 2;
    localparam int NLW = F + 3;
    localparam int RW  = F + 4;
    localparam int SW  = F + 30;
    localparam logic signed [UW-1:0] ONE_F = UW'(1) << F;

    // per-channel constant products, channel 0 is red
    logic [23:0] ak_reg [3];
    logic [23:0] dk_reg [3];
    logic [23:0] sk_reg [3];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            ak_reg[c] <= 24'(ambient_color[8*(2-c) +: 8]) * 24'(ambient_reflect[16*(2-c) +: 16]);
            dk_reg[c] <= 24'(light_color[8*(2-c) +: 8]) * 24'(diffuse_reflect[16*(2-c) +: 16]);
            sk_reg[c] <= 24'(light_color[8*(2-c) +: 8]) * 24'(specular_reflect[16*(2-c) +: 16]);
        end
    end

    logic signed [2*UW-1:0] nlp1_reg [3];
    logic signed [UW-1:0]   n1_reg [3];
    logic signed [UW-1:0]   l1_reg [3];
    logic signed [UW-1:0]   v1_reg [3];
    logic signed [NLW-1:0]  nl2_reg;
    logic signed [UW-1:0]   n2_reg [3];
    logic signed [UW-1:0]   l2_reg [3];
    logic signed [UW-1:0]   v2_reg [3];
    logic signed [NLW+UW:0] t3_reg [3];
    logic signed [UW-1:0]   l3_reg [3];
    logic signed [UW-1:0]   v3_reg [3];
    logic signed [NLW-1:0]  nl3_reg;
    logic signed [RW-1:0]   r4_reg [3];
    logic signed [UW-1:0]   v4_reg [3];
    logic signed [NLW-1:0]  nl4_reg;
    logic signed [RW+UW-1:0] rvp5_reg [3];
    logic signed [NLW-1:0]  nl5_reg;
    logic signed [UW-1:0]   rv_reg [0:P];
    logic signed [UW-1:0]   p_reg  [0:P];
    logic signed [NLW-1:0]  nl_reg [0:P];

    logic signed [63:0] nl_sum_c;
    logic signed [63:0] rv_sum_c;
    logic signed [63:0] rv_rnd_c;

    assign nl_sum_c = 64'(nlp1_reg[0]) + 64'(nlp1_reg[1]) + 64'(nlp1_reg[2]);
    assign rv_sum_c = 64'(rvp5_reg[0]) + 64'(rvp5_reg[1]) + 64'(rvp5_reg[2]);
    assign rv_rnd_c = pvl_pkg::rshr(rv_sum_c, F);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nlp1_reg[i] <= n_unit[i] * l_unit[i];
                n1_reg[i]   <= n_unit[i];
                l1_reg[i]   <= l_unit[i];
                v1_reg[i]   <= v_unit[i];
                n2_reg[i]   <= n1_reg[i];
                l2_reg[i]   <= l1_reg[i];
                v2_reg[i]   <= v1_reg[i];
                t3_reg[i]   <= ((NLW+UW+1)'(nl2_reg) * (NLW+UW+1)'(n2_reg[i])) <<< 1;
                l3_reg[i]   <= l2_reg[i];
                v3_reg[i]   <= v2_reg[i];
                r4_reg[i]   <= RW'(pvl_pkg::rshr(64'(t3_reg[i]), F)) - RW'(l3_reg[i]);
                v4_reg[i]   <= v3_reg[i];
                rvp5_reg[i] <= (RW+UW)'(r4_reg[i]) * (RW+UW)'(v4_reg[i]);
            end
            nl2_reg <= NLW'(pvl_pkg::rshr(nl_sum_c, F));
            nl3_reg <= nl2_reg;
            nl4_reg <= nl3_reg;
            nl5_reg <= nl4_reg;
            nl_reg[0] <= nl5_reg;
            p_reg[0]  <= ONE_F;
            if (rv_rnd_c > 64'(ONE_F))
            begin
                rv_reg[0] <= ONE_F;
            end
            else if (rv_rnd_c < -64'(ONE_F))
            begin
                rv_reg[0] <= -ONE_F;
            end
            else
            begin
                rv_reg[0] <= UW'(rv_rnd_c);
            end
        end
    end

    for (genvar k = 1; k <= P; k++)
    begin : g_pow
        logic signed [2*UW-1:0] prod_c;
        assign prod_c = (2*UW)'(p_reg[k-1]) * (2*UW)'(rv_reg[k-1]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k]  <= UW'(pvl_pkg::rshr(64'(prod_c), F));
                rv_reg[k] <= rv_reg[k-1];
                nl_reg[k] <= nl_reg[k-1];
            end
        end
    end

    logic signed [SW-1:0] ta_reg [3];
    logic signed [SW-1:0] td_reg [3];
    logic signed [SW-1:0] ts_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ta_reg[c] <= $signed(SW'(ak_reg[c])) <<< F;
                td_reg[c] <= $signed(SW'(dk_reg[c])) * SW'(nl_reg[P]);
                ts_reg[c] <= $signed(SW'(sk_reg[c])) * SW'(p_reg[P]);
            end
        end
    end

    logic signed [SW-1:0] sum_c [3];
    logic        [SW-1:0] rnd_c [3];
    logic [2:0][7:0]      color_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_c[c] = ta_reg[c] + td_reg[c] + ts_reg[c];
            rnd_c[c] = (SW'(sum_c[c]) + (SW'(1) << (14 + F))) >> (15 + F);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (sum_c[c] <= 0)
                begin
                    color_reg[c] <= 8'd0;
                end
                else if (rnd_c[c] > SW'(255))
                begin
                    color_reg[c] <= 8'd255;
                end
                else
                begin
                    color_reg[c] <= rnd_c[c][7:0];
                end
            end
        end
    end

    assign color = color_reg;

endmodule

// ----- design/phong_vertex_lighting.sv -----
// channel   dir  fields (lowest bits first)
// s_axis    in   tdata: normal_x, normal_y, normal_z (signed 16 each)
// m_axis    out  tdata: red, green, blue (8 each)
// cfg       in   index 0..6, data up to 48 bits, always ready
//
// One normal per cycle while the output is not stalled; the pipeline depth is set by
// the 32-stage square root and the one-bit-per-stage divider.
// The pipeline moves as one: it stalls only while a result waits at the output.
// Reset clears valid bits and config registers; view_direction resets to (0,0,16384).
module phong_vertex_lighting #(
    parameter int SPECULAR_POWER = pvl_pkg::SPECULAR_POWER_DEF,
    parameter int COMPONENT_BITS = pvl_pkg::COMPONENT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // normal_x, normal_y, normal_z
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // red, green, blue
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pvl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pvl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int F   = COMPONENT_BITS;
    localparam int LAT = pvl_pkg::norm_latency(F) + pvl_pkg::shade_latency(SPECULAR_POWER);

    logic [23:0] ambient_color_reg;
    logic [23:0] light_color_reg;
    logic [47:0] light_direction_reg;
    logic [47:0] view_direction_reg;
    logic [47:0] ambient_reflect_reg;
    logic [47:0] diffuse_reflect_reg;
    logic [47:0] specular_reflect_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_color_reg    <= '0;
            light_color_reg      <= '0;
            light_direction_reg  <= '0;
            view_direction_reg   <= pvl_pkg::VIEW_DIR_RESET;
            ambient_reflect_reg  <= '0;
            diffuse_reflect_reg  <= '0;
            specular_reflect_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pvl_pkg::reg_index_t'(cfg_index))
                pvl_pkg::REG_AMBIENT_COLOR:    ambient_color_reg    <= cfg_data[23:0];
                pvl_pkg::REG_LIGHT_COLOR:      light_color_reg      <= cfg_data[23:0];
                pvl_pkg::REG_LIGHT_DIRECTION:  light_direction_reg  <= cfg_data;
                pvl_pkg::REG_VIEW_DIRECTION:   view_direction_reg   <= cfg_data;
                pvl_pkg::REG_AMBIENT_REFLECT:  ambient_reflect_reg  <= cfg_data;
                pvl_pkg::REG_DIFFUSE_REFLECT:  diffuse_reflect_reg  <= cfg_data;
                pvl_pkg::REG_SPECULAR_REFLECT: specular_reflect_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    logic signed [15:0]  nvec [3];
    logic signed [15:0]  lvec [3];
    logic signed [15:0]  vvec [3];
    logic signed [F+1:0] n_unit [3];
    logic signed [F+1:0] l_unit [3];
    logic signed [F+1:0] v_unit [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nvec[i] = $signed(s_tdata[16*i +: 16]);
            lvec[i] = $signed(light_direction_reg[16*(2-i) +: 16]);
            vvec[i] = $signed(view_direction_reg[16*(2-i) +: 16]);
        end
    end

    pvl_norm #(.F(F)) u_norm_n (.clk(clk), .en(en), .vec(nvec), .unit(n_unit));
    pvl_norm #(.F(F)) u_norm_l (.clk(clk), .en(en), .vec(lvec), .unit(l_unit));
    pvl_norm #(.F(F)) u_norm_v (.clk(clk), .en(en), .vec(vvec), .unit(v_unit));

    logic [2:0][7:0] color;

    pvl_shade #(.F(F), .P(SPECULAR_POWER)) u_shade (
        .clk              (clk),
        .en               (en),
        .n_unit           (n_unit),
        .l_unit           (l_unit),
        .v_unit           (v_unit),
        .ambient_color    (ambient_color_reg),
        .light_color      (light_color_reg),
        .ambient_reflect  (ambient_reflect_reg),
        .diffuse_reflect  (diffuse_reflect_reg),
        .specular_reflect (specular_reflect_reg),
        .color            (color)
    );

    assign m_tdata = {color[2], color[1], color[0]};

`ifndef ASSERT_OFF
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[LAT-2]))
        else $error("result appeared without a request behind it");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
